// ===== hdl/lrupr_pkg.sv =====
// Package: word types and fixed field widths for the LRU page replacement block.
package lrupr_pkg;

	localparam int PAGE_W = 16;
	localparam int FIDX_W = 2;
	localparam int CNT_W  = 32;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef struct packed {
		logic [PAGE_W-1:0] page;
	} req_word_t;

	typedef struct packed {
		logic              hit;
		logic [FIDX_W-1:0] frame_index;
		logic              evicted_valid;
		logic [PAGE_W-1:0] evicted_page;
		logic [CNT_W-1:0]  fault_total;
		logic [CNT_W-1:0]  hit_total;
	} rsp_word_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + CNT_W'(1);
	endfunction

endpackage

// ===== hdl/lrupr_word_if.sv =====
// Interface: valid/ready channel carrying one word.
interface lrupr_word_if #(
	parameter type word_t = logic
);
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/lru_page_replacement.sv =====
// Top level: LRU page replacement over a small fully associative frame table.
//
// channel | dir | word       | fields
// --------+-----+------------+-------------------------------------------------------------
// req     | in  | req_word_t | page
// rsp     | out | rsp_word_t | hit, frame_index, evicted_valid, evicted_page, totals
//
// One reference per cycle sustained while rsp is not stalled; an accepted word reaches rsp
// through the input register, then the result register. LRU choice uses a registered pairwise
// age matrix, so the frame table is read and updated in a single pass.
// arst_n clears valid bits, time stamps, age matrix, counters and both valid flags.
// A stalled rsp holds its word; req keeps accepting while the input register can move.
module lru_page_replacement #(
	parameter int FRAMES    = 4,
	parameter int PAGE_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	lrupr_word_if.sink   req,
	lrupr_word_if.source rsp
);

	localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

	logic                 vld_s1;
	logic [PAGE_BITS-1:0] page_s1;

	logic [PAGE_BITS-1:0]            frame_page_q [FRAMES];
	logic [FRAMES-1:0]               frame_valid_q;
	logic [lrupr_pkg::CNT_W-1:0]     last_use_q   [FRAMES];
	logic [FRAMES-1:0]               older_q      [FRAMES];
	logic [lrupr_pkg::CNT_W-1:0]     ref_num_q;
	logic [lrupr_pkg::CNT_W-1:0]     fault_q;
	logic [lrupr_pkg::CNT_W-1:0]     hitc_q;

	logic                 out_vld_q;
	lrupr_pkg::rsp_word_t out_q;

	logic adv;
	logic take;

	logic [PAGE_BITS+lrupr_pkg::PAGE_W-1:0] page_ext;
	logic [FRAMES-1:0] match;
	logic [FRAMES-1:0] cand;
	logic              hit;
	logic              any_empty;
	logic [IDX_W-1:0]  hit_idx;
	logic [IDX_W-1:0]  empty_idx;
	logic [IDX_W-1:0]  victim_idx;
	logic [IDX_W-1:0]  idx;
	logic              evict;
	logic [PAGE_BITS+lrupr_pkg::PAGE_W-1:0] ev_ext;
	logic [IDX_W+lrupr_pkg::FIDX_W-1:0]     idx_ext;
	logic [lrupr_pkg::CNT_W-1:0] fault_nx;
	logic [lrupr_pkg::CNT_W-1:0] hitc_nx;

	assign adv       = !out_vld_q || rsp.ready;
	assign req.ready = !vld_s1 || adv;
	assign take      = vld_s1 && adv;
	assign page_ext  = {{PAGE_BITS{1'b0}}, req.data.page};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req.ready) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			page_s1 <= page_ext[PAGE_BITS-1:0];
		end
	end

	always_comb begin
		match      = '0;
		cand       = '0;
		hit_idx    = '0;
		empty_idx  = '0;
		victim_idx = '0;
		for (int i = 0; i < FRAMES; i++) begin
			match[i] = frame_valid_q[i] && (frame_page_q[i] == page_s1);
			cand[i]  = 1'b1;
			for (int j = 0; j < FRAMES; j++) begin
				if (j < i) begin
					cand[i] = cand[i] && older_q[i][j];
				end else if (j > i) begin
					cand[i] = cand[i] && !older_q[j][i];
				end
			end
		end
		for (int i = FRAMES - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_idx = IDX_W'(i);
			end
			if (!frame_valid_q[i]) begin
				empty_idx = IDX_W'(i);
			end
			if (cand[i]) begin
				victim_idx = IDX_W'(i);
			end
		end
		hit       = |match;
		any_empty = !(&frame_valid_q);
		evict     = !hit && !any_empty;
		if (hit) begin
			idx = hit_idx;
		end else if (any_empty) begin
			idx = empty_idx;
		end else begin
			idx = victim_idx;
		end
		ev_ext   = {{lrupr_pkg::PAGE_W{1'b0}}, frame_page_q[idx]};
		idx_ext  = {{lrupr_pkg::FIDX_W{1'b0}}, idx};
		fault_nx = hit ? fault_q : lrupr_pkg::sat_inc(fault_q);
		hitc_nx  = hit ? lrupr_pkg::sat_inc(hitc_q) : hitc_q;
	end

	// frame table state; older_q[i][j] mirrors last_use[i] < last_use[j]
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_q <= '0;
			ref_num_q     <= '0;
			fault_q       <= '0;
			hitc_q        <= '0;
			for (int i = 0; i < FRAMES; i++) begin
				last_use_q[i] <= '0;
				older_q[i]    <= '0;
			end
		end else if (take) begin
			frame_valid_q[idx] <= 1'b1;
			last_use_q[idx]    <= ref_num_q;
			ref_num_q          <= lrupr_pkg::sat_inc(ref_num_q);
			fault_q            <= fault_nx;
			hitc_q             <= hitc_nx;
			for (int i = 0; i < FRAMES; i++) begin
				for (int j = 0; j < FRAMES; j++) begin
					if (IDX_W'(i) == idx) begin
						older_q[i][j] <= 1'b0;
					end else if (IDX_W'(j) == idx) begin
						older_q[i][j] <= last_use_q[i] < ref_num_q;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && !hit) begin
			frame_page_q[idx] <= page_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q.hit           <= hit;
			out_q.frame_index   <= idx_ext[lrupr_pkg::FIDX_W-1:0];
			out_q.evicted_valid <= evict;
			out_q.evicted_page  <= evict ? ev_ext[lrupr_pkg::PAGE_W-1:0] : '0;
			out_q.fault_total   <= fault_nx;
			out_q.hit_total     <= hitc_nx;
		end
	end

	assign rsp.valid = out_vld_q;
	assign rsp.data  = out_q;

endmodule
